// ----- rtl/core/ewt_pkg.sv -----
package ewt_pkg;

  localparam int WatchSlots = 64;
  localparam int EventLimit = 32;
  localparam int FdCount    = 256;

  localparam int SlotAw = (WatchSlots > 1) ? $clog2(WatchSlots) : 1;
  localparam int SlotCw = $clog2(WatchSlots + 1);
  localparam int FdAw   = $clog2(FdCount);
  localparam int CntW   = $clog2(EventLimit + 1);

  // event bits (mask and reported events)
  localparam logic [3:0] EvIn  = 4'h1;
  localparam logic [3:0] EvOut = 4'h2;
  localparam logic [3:0] EvErr = 4'h4;
  localparam logic [3:0] EvHup = 4'h8;
  localparam int         OneshotBit = 4;
  localparam logic [4:0] RdNval = 5'h10;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_MOD    = 3'd1,
    KIND_DEL    = 3'd2,
    KIND_WAIT   = 3'd3,
    KIND_UPDATE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_INVAL = 3'd1,
    ST_EXIST = 3'd2,
    ST_NOENT = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  fd;
    logic [4:0]  event_mask;
    logic [63:0] user_data;
    logic [5:0]  max_events;
    logic [4:0]  ready_bits;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  ready_events;
    logic [63:0] event_data;
    logic [5:0]  ready_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  fd;
    logic [4:0]  mask;
    logic [63:0] data;
  } slot_t;

  // nval is reported as err
  function automatic logic [3:0] ready_to_events(logic [4:0] rd);
    logic [3:0] ev;
    ev = rd[3:0];
    if (rd[4]) begin
      ev = ev | EvErr;
    end
    return ev;
  endfunction

endpackage

// ----- rtl/core/event_watch_table.sv -----
// Watch table of descriptors with event masks and user data. An item is taken
// when start is high and busy is low; results come out one per strobe on
// res_valid_o and cannot be held off. Readiness updates and rejected items
// give their single result the cycle after start and never raise busy. Add,
// modify and delete walk the slot memory one slot a cycle to find the
// descriptor and stop early when it is found. A wait streams the slots
// through a three-step pipeline (slot read, readiness read, event check), one
// slot a cycle; it stops as soon as max_events entries are found. Ready
// entries come out at most one a cycle, the final one marked by last.
module event_watch_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ewt_pkg::req_t      req_i,
  output logic               res_valid_o,
  output ewt_pkg::res_t      res_o
);

  localparam int SlotAw = ewt_pkg::SlotAw;
  localparam int SlotCw = ewt_pkg::SlotCw;
  localparam int FdAw   = ewt_pkg::FdAw;
  localparam int CntW   = ewt_pkg::CntW;

  ewt_pkg::state_e state_q, state_d;
  ewt_pkg::req_t   req_q, req_d;

  logic [SlotCw-1:0] iss_q, iss_d;
  logic              a_v_q, a_v_d;
  logic [SlotAw-1:0] a_idx_q, a_idx_d;
  logic              b_v_q, b_v_d;
  logic [SlotAw-1:0] b_idx_q, b_idx_d;
  logic [4:0]        b_mask_q, b_mask_d;
  logic [63:0]       b_data_q, b_data_d;
  logic              b_fdok_q, b_fdok_d;
  logic              free_v_q, free_v_d;
  logic [SlotAw-1:0] free_idx_q, free_idx_d;
  logic [CntW-1:0]   n_q, n_d;
  logic              pend_v_q, pend_v_d;
  logic [3:0]        pend_ev_q, pend_ev_d;
  logic [63:0]       pend_data_q, pend_data_d;
  ewt_pkg::res_t     res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic [ewt_pkg::WatchSlots-1:0] active_q;
  logic [ewt_pkg::FdCount-1:0]    rdy_vld_q;

  ewt_pkg::slot_t slot_mem [ewt_pkg::WatchSlots];
  ewt_pkg::slot_t slot_rd_q;
  logic [4:0]     rdy_mem [ewt_pkg::FdCount];
  logic [4:0]     rdy_rd_q;
  logic           rdy_hit_q;

  logic              slot_re, slot_we;
  logic [SlotAw-1:0] slot_raddr, slot_waddr;
  ewt_pkg::slot_t    slot_wdata;
  logic              rdy_re, rdy_we;
  logic [FdAw-1:0]   rdy_raddr, rdy_waddr;
  logic              act_set, act_clr;
  logic [SlotAw-1:0] act_idx;

  logic              issue;
  logic              a_act, a_hit, a_lastslot, free_now;
  logic [SlotAw-1:0] free_sel;
  logic [4:0]        b_rd;
  logic [3:0]        b_ev;
  logic              b_fire, b_lastslot;

  // slot memory
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // readiness memory; never-written entries read as zero through the valid bits
  // updates are written straight from the accepted item
  always_ff @(posedge clk_i) begin
    if (rdy_we) begin
      rdy_mem[rdy_waddr] <= req_i.ready_bits;
    end
    if (rdy_re) begin
      rdy_rd_q  <= rdy_mem[rdy_raddr];
      rdy_hit_q <= rdy_vld_q[rdy_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_vld_q <= '0;
      active_q  <= '0;
    end else begin
      if (rdy_we) begin
        rdy_vld_q[rdy_waddr] <= 1'b1;
      end
      if (act_set) begin
        active_q[act_idx] <= 1'b1;
      end
      if (act_clr) begin
        active_q[act_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ewt_pkg::S_IDLE;
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      free_v_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
      iss_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      a_v_q       <= a_v_d;
      b_v_q       <= b_v_d;
      free_v_q    <= free_v_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
      iss_q       <= iss_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    a_idx_q     <= a_idx_d;
    b_idx_q     <= b_idx_d;
    b_mask_q    <= b_mask_d;
    b_data_q    <= b_data_d;
    b_fdok_q    <= b_fdok_d;
    free_idx_q  <= free_idx_d;
    pend_ev_q   <= pend_ev_d;
    pend_data_q <= pend_data_d;
    res_q       <= res_d;
  end

  // lookup step: slot data of a_idx_q is back
  assign a_act      = active_q[a_idx_q];
  assign a_hit      = a_act && (slot_rd_q.fd == req_q.fd);
  assign a_lastslot = (a_idx_q == SlotAw'(ewt_pkg::WatchSlots - 1));
  assign free_now   = free_v_q || !a_act;
  assign free_sel   = free_v_q ? free_idx_q : a_idx_q;

  // event check step: readiness of b_idx_q's descriptor is back
  assign b_rd       = !b_fdok_q ? ewt_pkg::RdNval : (rdy_hit_q ? rdy_rd_q : 5'd0);
  assign b_ev       = ewt_pkg::ready_to_events(b_rd)
                      & (b_mask_q[3:0] | ewt_pkg::EvErr | ewt_pkg::EvHup);
  assign b_fire     = active_q[b_idx_q] && (b_ev != 4'd0);
  assign b_lastslot = (b_idx_q == SlotAw'(ewt_pkg::WatchSlots - 1));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    iss_d       = iss_q;
    free_v_d    = free_v_q;
    free_idx_d  = free_idx_q;
    n_d         = n_q;
    pend_v_d    = pend_v_q;
    pend_ev_d   = pend_ev_q;
    pend_data_d = pend_data_q;
    res_d       = res_q;
    res_valid_d = 1'b0;

    slot_we    = 1'b0;
    slot_waddr = a_idx_q;
    slot_wdata = '{fd: req_q.fd, mask: req_q.event_mask, data: req_q.user_data};
    rdy_we     = 1'b0;
    rdy_waddr  = FdAw'(req_i.fd);
    rdy_re     = 1'b0;
    rdy_raddr  = FdAw'(slot_rd_q.fd);
    act_set    = 1'b0;
    act_clr    = 1'b0;
    act_idx    = a_idx_q;

    issue = ((state_q == ewt_pkg::S_LOOK) || (state_q == ewt_pkg::S_SCAN))
            && (iss_q < SlotCw'(ewt_pkg::WatchSlots));
    slot_re    = issue;
    slot_raddr = iss_q[SlotAw-1:0];
    a_v_d      = issue;
    a_idx_d    = iss_q[SlotAw-1:0];
    if (issue) begin
      iss_d = iss_q + SlotCw'(1);
    end

    b_v_d    = 1'b0;
    b_idx_d  = a_idx_q;
    b_mask_d = slot_rd_q.mask;
    b_data_d = slot_rd_q.data;
    b_fdok_d = 32'(slot_rd_q.fd) < 32'(ewt_pkg::FdCount);

    case (state_q)
      ewt_pkg::S_IDLE: begin
        if (start) begin
          req_d    = req_i;
          iss_d    = '0;
          free_v_d = 1'b0;
          n_d      = '0;
          pend_v_d = 1'b0;
          res_d    = '{status: ewt_pkg::ST_INVAL, ready_events: 4'd0, event_data: 64'd0,
                       ready_count: 6'd0, last: 1'b1};
          case (ewt_pkg::kind_e'(req_i.kind))
            ewt_pkg::KIND_ADD, ewt_pkg::KIND_MOD, ewt_pkg::KIND_DEL: begin
              state_d = ewt_pkg::S_LOOK;
            end
            ewt_pkg::KIND_WAIT: begin
              if ((req_i.max_events == 6'd0)
                  || (32'(req_i.max_events) > 32'(ewt_pkg::EventLimit))) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = ewt_pkg::S_SCAN;
              end
            end
            ewt_pkg::KIND_UPDATE: begin
              res_valid_d = 1'b1;
              if (32'(req_i.fd) < 32'(ewt_pkg::FdCount)) begin
                rdy_we       = 1'b1;
                res_d.status = ewt_pkg::ST_OK;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      ewt_pkg::S_LOOK: begin
        if (a_v_q) begin
          free_v_d   = free_now;
          free_idx_d = free_sel;
          if (a_hit || a_lastslot) begin
            state_d     = ewt_pkg::S_IDLE;
            res_valid_d = 1'b1;
            res_d       = '{status: ewt_pkg::ST_OK, ready_events: 4'd0, event_data: 64'd0,
                            ready_count: 6'd0, last: 1'b1};
            case (ewt_pkg::kind_e'(req_q.kind))
              ewt_pkg::KIND_ADD: begin
                if (a_hit) begin
                  res_d.status = ewt_pkg::ST_EXIST;
                end else if (free_now) begin
                  slot_we    = 1'b1;
                  slot_waddr = free_sel;
                  act_set    = 1'b1;
                  act_idx    = free_sel;
                end else begin
                  res_d.status = ewt_pkg::ST_FULL;
                end
              end
              ewt_pkg::KIND_MOD: begin
                if (a_hit) begin
                  slot_we = 1'b1;
                end else begin
                  res_d.status = ewt_pkg::ST_NOENT;
                end
              end
              ewt_pkg::KIND_DEL: begin
                if (a_hit) begin
                  act_clr = 1'b1;
                end else begin
                  res_d.status = ewt_pkg::ST_NOENT;
                end
              end
              default: begin
                res_d.status = ewt_pkg::ST_INVAL;
              end
            endcase
          end
        end
      end

      ewt_pkg::S_SCAN: begin
        if (a_v_q) begin
          rdy_re = 1'b1;
          b_v_d  = 1'b1;
        end
        if (b_v_q) begin
          if (b_fire) begin
            // one ready entry is held back until it is known whether it is the last
            if (pend_v_q) begin
              res_valid_d = 1'b1;
              res_d = '{status: ewt_pkg::ST_OK, ready_events: pend_ev_q,
                        event_data: pend_data_q, ready_count: 6'd0, last: 1'b0};
            end
            pend_v_d    = 1'b1;
            pend_ev_d   = b_ev;
            pend_data_d = b_data_q;
            n_d         = n_q + CntW'(1);
            if (b_mask_q[ewt_pkg::OneshotBit]) begin
              act_clr = 1'b1;
              act_idx = b_idx_q;
            end
            if ((7'(n_q) + 7'd1) == 7'(req_q.max_events)) begin
              state_d = ewt_pkg::S_FIN;
            end
          end
          if (b_lastslot) begin
            state_d = ewt_pkg::S_FIN;
          end
        end
      end

      ewt_pkg::S_FIN: begin
        state_d     = ewt_pkg::S_IDLE;
        res_valid_d = 1'b1;
        if (pend_v_q) begin
          res_d = '{status: ewt_pkg::ST_OK, ready_events: pend_ev_q, event_data: pend_data_q,
                    ready_count: 6'(n_q), last: 1'b1};
        end else begin
          res_d = '{status: ewt_pkg::ST_OK, ready_events: 4'd0, event_data: 64'd0,
                    ready_count: 6'd0, last: 1'b1};
        end
      end

      default: begin
        state_d = ewt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ewt_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ewt_pkg::*;

  localparam logic [2:0] KindBadLo = 3'd5;
  localparam logic [2:0] KindBadHi = 3'd7;
  localparam int DrainCap = 20000;

  typedef struct {
    req_t    req;
    bit      typed;
    status_e st;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic res_valid_o;
  res_t res_o;

  // shadow of the watch table and readiness store
  logic       shadow_act  [WatchSlots];
  logic [7:0] shadow_fd   [WatchSlots];
  logic [4:0] shadow_mask [WatchSlots];
  logic [63:0] shadow_data [WatchSlots];
  logic [4:0] shadow_ready [FdCount];

  res_t pending_results[$];
  res_t step_out[$];
  row_t dir_rows[$];
  int   err_count;
  int   burst_left;

  event_watch_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic req_t mk_req(logic [2:0] kind, logic [7:0] fd, logic [4:0] mask,
                                  logic [63:0] data, logic [5:0] maxev, logic [4:0] rbits);
    req_t r;
    r.kind       = kind;
    r.fd         = fd;
    r.event_mask = mask;
    r.user_data  = data;
    r.max_events = maxev;
    r.ready_bits = rbits;
    return r;
  endfunction

  function automatic res_t status_only(status_e st);
    res_t r;
    r = '{st, 4'h0, 64'h0, 6'h0, 1'b1};
    return r;
  endfunction

  function automatic int find_watch(logic [7:0] fd);
    for (int i = 0; i < WatchSlots; i++) begin
      if (shadow_act[i] && shadow_fd[i] == fd) begin
        return i;
      end
    end
    return -1;
  endfunction

  // works out the results of one item and advances the shadow table
  task automatic predict_watch_op(input req_t r);
    int         slot;
    int         n;
    logic [4:0] rd;
    logic [3:0] ev;
    res_t       tail;
    step_out.delete();
    case (r.kind)
      KIND_ADD: begin
        slot = find_watch(r.fd);
        if (slot >= 0) begin
          step_out.push_back(status_only(ST_EXIST));
        end else begin
          slot = -1;
          for (int i = WatchSlots - 1; i >= 0; i--) begin
            if (!shadow_act[i]) slot = i;
          end
          if (slot < 0) begin
            step_out.push_back(status_only(ST_FULL));
          end else begin
            shadow_act[slot]  = 1'b1;
            shadow_fd[slot]   = r.fd;
            shadow_mask[slot] = r.event_mask;
            shadow_data[slot] = r.user_data;
            step_out.push_back(status_only(ST_OK));
          end
        end
      end
      KIND_MOD: begin
        slot = find_watch(r.fd);
        if (slot < 0) begin
          step_out.push_back(status_only(ST_NOENT));
        end else begin
          shadow_mask[slot] = r.event_mask;
          shadow_data[slot] = r.user_data;
          step_out.push_back(status_only(ST_OK));
        end
      end
      KIND_DEL: begin
        slot = find_watch(r.fd);
        if (slot < 0) begin
          step_out.push_back(status_only(ST_NOENT));
        end else begin
          shadow_act[slot] = 1'b0;
          step_out.push_back(status_only(ST_OK));
        end
      end
      KIND_WAIT: begin
        if (r.max_events == 0 || r.max_events > EventLimit) begin
          step_out.push_back(status_only(ST_INVAL));
        end else begin
          n = 0;
          for (int i = 0; i < WatchSlots && n < r.max_events; i++) begin
            if (shadow_act[i]) begin
              rd = (shadow_fd[i] < FdCount) ? shadow_ready[shadow_fd[i]] : RdNval;
              // nval shows up as err; err and hup always pass the mask
              ev = rd[3:0] | (rd[4] ? EvErr : 4'h0);
              ev = ev & (shadow_mask[i][3:0] | EvErr | EvHup);
              if (ev != 4'h0) begin
                step_out.push_back('{ST_OK, ev, shadow_data[i], 6'h0, 1'b0});
                n++;
                if (shadow_mask[i][OneshotBit]) shadow_act[i] = 1'b0;
              end
            end
          end
          if (n == 0) begin
            step_out.push_back(status_only(ST_OK));
          end else begin
            tail = step_out.pop_back();
            tail.ready_count = 6'(n);
            tail.last = 1'b1;
            step_out.push_back(tail);
          end
        end
      end
      KIND_UPDATE: begin
        if (r.fd >= FdCount) begin
          step_out.push_back(status_only(ST_INVAL));
        end else begin
          shadow_ready[r.fd] = r.ready_bits;
          step_out.push_back(status_only(ST_OK));
        end
      end
      default: step_out.push_back(status_only(ST_INVAL));
    endcase
  endtask

  // bursts of items with random gaps; returns once the item is taken
  task automatic send_item(input req_t r, input bit typed, input status_e st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_watch_op(r);
    if (typed) begin
      pending_results.push_back(status_only(st));
    end else begin
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    end
  endtask

  function automatic req_t rand_item();
    int          pick;
    logic [2:0]  kind;
    logic [7:0]  fd;
    logic [5:0]  maxev;
    pick  = $urandom_range(0, 99);
    fd    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 11));
    maxev = 6'($urandom_range(1, EventLimit));
    if (pick < 25)      kind = KIND_ADD;
    else if (pick < 40) kind = KIND_MOD;
    else if (pick < 55) kind = KIND_DEL;
    else if (pick < 78) kind = KIND_UPDATE;
    else if (pick < 96) kind = KIND_WAIT;
    else                kind = 3'($urandom_range(KindBadLo, KindBadHi));
    if (pick >= 93 && pick < 96) begin
      maxev = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(EventLimit + 1, 63));
    end
    return mk_req(kind, fd, 5'($urandom_range(0, 31)), {$urandom, $urandom}, maxev,
                  5'($urandom_range(0, 31)));
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(rand_item(), 1'b0, ST_OK);
    end
  endtask

  // fill the table past capacity, light many entries, drain with long waits
  task automatic run_fill();
    logic [7:0] fd;
    for (int i = 0; i < WatchSlots + 4; i++) begin
      send_item(mk_req(KIND_ADD, 8'(128 + i), 5'($urandom_range(0, 31)), {$urandom, $urandom},
                       6'($urandom), 5'($urandom)), 1'b0, ST_OK);
    end
    for (int i = 0; i < 30; i++) begin
      fd = 8'($urandom_range(128, 128 + WatchSlots + 3));
      send_item(mk_req(KIND_UPDATE, fd, 5'($urandom), {$urandom, $urandom}, 6'($urandom),
                       5'($urandom_range(1, 31))), 1'b0, ST_OK);
    end
    for (int i = 0; i < 4; i++) begin
      send_item(mk_req(KIND_WAIT, 8'($urandom), 5'($urandom), {$urandom, $urandom},
                       (i == 2) ? 6'd20 : 6'(EventLimit), 5'($urandom)), 1'b0, ST_OK);
    end
    for (int i = 0; i < WatchSlots + 4; i++) begin
      send_item(mk_req(KIND_DEL, 8'(128 + i), 5'($urandom), {$urandom, $urandom},
                       6'($urandom), 5'($urandom)), 1'b0, ST_OK);
    end
  endtask

  initial begin
    int drained;
    err_count  = 0;
    burst_left = 0;
    start <= 1'b0;
    req   <= '0;
    foreach (shadow_act[i]) begin
      shadow_act[i]  = 1'b0;
      shadow_fd[i]   = '0;
      shadow_mask[i] = '0;
      shadow_data[i] = '0;
    end
    foreach (shadow_ready[i]) shadow_ready[i] = '0;

    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'd1, 5'h00), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_DEL, 8'd5, 5'h00, 64'h0, 6'd0, 5'h00), 1, ST_NOENT});
    dir_rows.push_back('{mk_req(KIND_MOD, 8'd5, 5'h1f, 64'h0, 6'd0, 5'h00), 1, ST_NOENT});
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'd0, 5'h00), 1, ST_INVAL});
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'(EventLimit + 1), 5'h00),
                         1, ST_INVAL});
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'hff, 5'h1f, '1, 6'd63, 5'h1f), 1, ST_INVAL});
    dir_rows.push_back('{mk_req(3'd5, 8'd1, 5'h01, 64'h1, 6'd1, 5'h01), 1, ST_INVAL});
    dir_rows.push_back('{mk_req(3'd6, 8'd2, 5'h02, 64'h2, 6'd2, 5'h02), 1, ST_INVAL});
    dir_rows.push_back('{mk_req(KindBadHi, 8'hff, 5'h1f, '1, 6'd63, 5'h1f), 1, ST_INVAL});
    dir_rows.push_back('{mk_req(KIND_ADD, 8'd0, 5'h0f, '1, 6'd0, 5'h00), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_ADD, 8'd0, 5'h00, 64'h0, 6'd0, 5'h00), 1, ST_EXIST});
    dir_rows.push_back('{mk_req(KIND_ADD, 8'hff, 5'h13, 64'h0, 6'd0, 5'h00), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_UPDATE, 8'd0, 5'h00, 64'h0, 6'd0, 5'h1f), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_UPDATE, 8'hff, 5'h00, 64'h0, 6'd0, 5'h01), 1, ST_OK});
    // one-shot on fd 255 fires here and drops out of the next wait
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'(EventLimit), 5'h00), 0, ST_OK});
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'(EventLimit), 5'h00), 0, ST_OK});
    dir_rows.push_back('{mk_req(KIND_MOD, 8'hff, 5'h01, 64'h0, 6'd0, 5'h00), 1, ST_NOENT});
    dir_rows.push_back('{mk_req(KIND_MOD, 8'd0, 5'h00, 64'h0123_4567_89ab_cdef, 6'd0, 5'h00),
                         1, ST_OK});
    // nval alone still reports err with an empty interest mask
    dir_rows.push_back('{mk_req(KIND_UPDATE, 8'd0, 5'h00, 64'h0, 6'd0, RdNval), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'd1, 5'h00), 0, ST_OK});
    dir_rows.push_back('{mk_req(KIND_DEL, 8'd0, 5'h00, 64'h0, 6'd0, 5'h00), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_DEL, 8'd0, 5'h00, 64'h0, 6'd0, 5'h00), 1, ST_NOENT});
    dir_rows.push_back('{mk_req(KIND_WAIT, 8'd0, 5'h00, 64'h0, 6'(EventLimit), 5'h00), 1, ST_OK});
    dir_rows.push_back('{mk_req(KIND_UPDATE, 8'd0, 5'h00, 64'h0, 6'd0, 5'h00), 1, ST_OK});

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].st);
    end
    run_random(100);
    run_fill();
    run_random(100);
    start <= 1'b0;

    drained = 0;
    while (pending_results.size() != 0 && drained < DrainCap) begin
      @(posedge clk_i);
      drained++;
    end
    repeat (WatchSlots + 20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    res_t want;
    if (res_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, res_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, res_o.status);
          err_count++;
        end
        if (res_o.ready_events !== want.ready_events) begin
          $display("%0t: ready_events expected %h got %h", $time, want.ready_events,
                   res_o.ready_events);
          err_count++;
        end
        if (res_o.event_data !== want.event_data) begin
          $display("%0t: event_data expected %h got %h", $time, want.event_data,
                   res_o.event_data);
          err_count++;
        end
        if (res_o.ready_count !== want.ready_count) begin
          $display("%0t: ready_count expected %0d got %0d", $time, want.ready_count,
                   res_o.ready_count);
          err_count++;
        end
        if (res_o.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, res_o.last);
          err_count++;
        end
      end
    end
  end

endmodule
